// ===== sv/stale_result_follower_top_macros.svh =====
`ifndef STALE_RESULT_FOLLOWER_TOP_MACROS_SVH
`define STALE_RESULT_FOLLOWER_TOP_MACROS_SVH
`ifndef SYNTH
`define SRF_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("%m: assertion failed");
`define SRF_ASSERT_RST(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) (!rstn) |=> (prop)) \
		else $error("%m: reset assertion failed");
`else
`define SRF_ASSERT(lbl, clk, rstn, prop)
`define SRF_ASSERT_RST(lbl, clk, rstn, prop)
`endif
`endif

// ===== sv/srf_pkg.sv =====
package srf_pkg;

	localparam int GEN_W    = 32;
	localparam int DEB_W    = 16;
	localparam int MS_W     = 17;
	localparam int OP_W     = 3;
	localparam int ADDR_W   = 3;
	localparam int APB_W    = 32;
	localparam logic [15:0] DEBOUNCE_RST = 16'd300;

	// register index, taken from paddr[2]
	localparam logic REG_DEBOUNCE = 1'b0;

	typedef enum logic [2:0] {
		OP_OBSERVE     = 3'd0,
		OP_RUN_STARTED = 3'd1,
		OP_RUN_DONE    = 3'd2,
		OP_RUN_FAILED  = 3'd3,
		OP_ADOPT       = 3'd4,
		OP_CLEAR       = 3'd5
	} op_t;

	typedef enum logic [5:0] {
		MODE_NONE     = 6'b000001,
		MODE_CURRENT  = 6'b000010,
		MODE_DIRTY    = 6'b000100,
		MODE_STARTING = 6'b001000,
		MODE_UPDATING = 6'b010000,
		MODE_FAILED   = 6'b100000
	} mode_t;

	typedef enum logic [2:0] {
		ST_NONE     = 3'd0,
		ST_CURRENT  = 3'd1,
		ST_DIRTY    = 3'd2,
		ST_STARTING = 3'd3,
		ST_UPDATING = 3'd4,
		ST_FAILED   = 3'd5
	} state_code_t;

	typedef enum logic [1:0] {
		RSN_NONE     = 2'd0,
		RSN_GEOMETRY = 2'd1,
		RSN_SUN      = 2'd2,
		RSN_SAMPLING = 2'd3
	} reason_t;

	// first member sits in the top bits
	typedef struct packed {
		logic [GEN_W-1:0]        rerun_count;
		logic [GEN_W-1:0]        discarded_count;
		reason_t                 dirty_reason;
		state_code_t             follow_state;
		logic [GEN_W-1:0]        generation;
		logic signed [MS_W-1:0]  ms_until_start;
		logic                    should_start;
		logic                    changed;
	} result_t;

	function automatic state_code_t mode_code(input mode_t m);
		state_code_t c;
		case (m)
			MODE_NONE:     c = ST_NONE;
			MODE_CURRENT:  c = ST_CURRENT;
			MODE_DIRTY:    c = ST_DIRTY;
			MODE_STARTING: c = ST_STARTING;
			MODE_UPDATING: c = ST_UPDATING;
			MODE_FAILED:   c = ST_FAILED;
			default:       c = ST_NONE;
		endcase
		return c;
	endfunction

endpackage

// ===== sv/srf_cfg.sv =====
`include "stale_result_follower_top_macros.svh"

module srf_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [srf_pkg::ADDR_W-1:0]   paddr,
	input  logic [srf_pkg::APB_W-1:0]    pwdata,
	output logic [srf_pkg::APB_W-1:0]    prdata,
	output logic                         pready,
	output logic [srf_pkg::DEB_W-1:0]    debounce
);

	logic [srf_pkg::DEB_W-1:0] debounce_q;
	logic                      wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == srf_pkg::REG_DEBOUNCE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= srf_pkg::DEBOUNCE_RST;
		end else if (wr_en) begin
			debounce_q <= pwdata[srf_pkg::DEB_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == srf_pkg::REG_DEBOUNCE) begin
			prdata = {{(srf_pkg::APB_W-srf_pkg::DEB_W){1'b0}}, debounce_q};
		end else begin
			prdata = '0;
		end
	end

	assign debounce = debounce_q;

	`SRF_ASSERT(a_cfg_write, clk, arst_n, wr_en |=> debounce_q == $past(pwdata[15:0]))
	`SRF_ASSERT(a_cfg_hold, clk, arst_n, !wr_en |=> $stable(debounce_q))
	`SRF_ASSERT_RST(a_cfg_rst, clk, arst_n, debounce_q == srf_pkg::DEBOUNCE_RST)

endmodule

// ===== sv/srf_core.sv =====
`include "stale_result_follower_top_macros.svh"

module srf_core #(
	parameter int SIG_WIDTH  = 32,
	parameter int TIME_WIDTH = 48
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            advance,
	input  srf_pkg::op_t                    op,
	input  logic [2:0][SIG_WIDTH-1:0]       sig,
	input  logic [TIME_WIDTH-1:0]           now,
	input  logic [srf_pkg::GEN_W-1:0]       tag,
	input  logic [srf_pkg::DEB_W-1:0]       debounce,
	output srf_pkg::result_t                res
);

	localparam int GW = srf_pkg::GEN_W;

	function automatic srf_pkg::reason_t which_moved(
		input logic [2:0][SIG_WIDTH-1:0] a,
		input logic [2:0][SIG_WIDTH-1:0] b
	);
		srf_pkg::reason_t r;
		if (a[0] != b[0]) begin
			r = srf_pkg::RSN_GEOMETRY;
		end else if (a[1] != b[1]) begin
			r = srf_pkg::RSN_SUN;
		end else if (a[2] != b[2]) begin
			r = srf_pkg::RSN_SAMPLING;
		end else begin
			r = srf_pkg::RSN_NONE;
		end
		return r;
	endfunction

	srf_pkg::mode_t            mode_q, mode_d;
	srf_pkg::reason_t          reason_q, reason_d;
	logic [2:0][SIG_WIDTH-1:0] study_q, study_d;
	logic [2:0][SIG_WIDTH-1:0] world_q, world_d;
	logic [2:0][SIG_WIDTH-1:0] run_q, run_d;
	logic                      wk_q, wk_d;
	logic                      rk_q, rk_d;
	logic [GW-1:0]             gen_q, gen_d;
	logic [TIME_WIDTH-1:0]     ds_q, ds_d;
	logic [GW-1:0]             rr_q, rr_d;
	logic [GW-1:0]             disc_q, disc_d;

	logic                      stamp;
	logic                      changed;
	logic                      running;
	srf_pkg::reason_t          obs_why;
	srf_pkg::reason_t          done_why;
	logic [TIME_WIDTH-1:0]     elapsed;
	logic                      start;
	logic [srf_pkg::MS_W-1:0]  left;

	assign running  = (mode_q == srf_pkg::MODE_STARTING) || (mode_q == srf_pkg::MODE_UPDATING);
	assign obs_why  = which_moved((running && rk_q) ? run_q : study_q, sig);
	assign done_why = which_moved(sig, world_q);

	always_comb begin
		mode_d   = mode_q;
		reason_d = reason_q;
		study_d  = study_q;
		world_d  = world_q;
		run_d    = run_q;
		wk_d     = wk_q;
		rk_d     = rk_q;
		gen_d    = gen_q;
		ds_d     = ds_q;
		rr_d     = rr_q;
		disc_d   = disc_q;
		stamp    = 1'b0;
		changed  = 1'b0;
		case (op)
			srf_pkg::OP_OBSERVE: begin
				world_d = sig;
				wk_d    = 1'b1;
				if (mode_q != srf_pkg::MODE_NONE) begin
					if (obs_why == srf_pkg::RSN_NONE) begin
						if (mode_q == srf_pkg::MODE_DIRTY) begin
							mode_d   = srf_pkg::MODE_CURRENT;
							reason_d = srf_pkg::RSN_NONE;
							changed  = 1'b1;
						end
					end else if (mode_q == srf_pkg::MODE_DIRTY && reason_q == obs_why) begin
						stamp = (world_q != sig);
					end else begin
						gen_d    = gen_q + GW'(1);
						mode_d   = srf_pkg::MODE_DIRTY;
						rk_d     = 1'b0;
						reason_d = obs_why;
						stamp    = 1'b1;
						changed  = 1'b1;
					end
				end
			end
			srf_pkg::OP_RUN_STARTED: begin
				mode_d  = srf_pkg::MODE_UPDATING;
				world_d = sig;
				run_d   = sig;
				wk_d    = 1'b1;
				rk_d    = 1'b1;
				rr_d    = rr_q + GW'(1);
			end
			srf_pkg::OP_RUN_DONE: begin
				if (tag != gen_q) begin
					disc_d = disc_q + GW'(1);
				end else if (wk_q && done_why != srf_pkg::RSN_NONE) begin
					disc_d   = disc_q + GW'(1);
					gen_d    = gen_q + GW'(1);
					mode_d   = srf_pkg::MODE_DIRTY;
					rk_d     = 1'b0;
					reason_d = done_why;
					stamp    = 1'b1;
				end else begin
					study_d  = sig;
					world_d  = sig;
					wk_d     = 1'b1;
					mode_d   = srf_pkg::MODE_CURRENT;
					reason_d = srf_pkg::RSN_NONE;
					stamp    = 1'b1;
					rk_d     = 1'b0;
					changed  = 1'b1;
				end
			end
			srf_pkg::OP_RUN_FAILED: begin
				if (tag != gen_q) begin
					disc_d = disc_q + GW'(1);
				end else begin
					mode_d = srf_pkg::MODE_FAILED;
				end
			end
			srf_pkg::OP_ADOPT: begin
				study_d  = sig;
				world_d  = sig;
				wk_d     = 1'b1;
				mode_d   = srf_pkg::MODE_CURRENT;
				reason_d = srf_pkg::RSN_NONE;
				stamp    = 1'b1;
				rk_d     = 1'b0;
			end
			srf_pkg::OP_CLEAR: begin
				mode_d   = srf_pkg::MODE_NONE;
				reason_d = srf_pkg::RSN_NONE;
				study_d  = '0;
				world_d  = '0;
				run_d    = '0;
				wk_d     = 1'b0;
				rk_d     = 1'b0;
				gen_d    = gen_q + GW'(1);
				ds_d     = '0;
			end
			default: begin
			end
		endcase
		if (stamp) begin
			ds_d = now;
		end
	end

	// status uses the updated mode; a fresh stamp means nothing has elapsed
	always_comb begin
		if (stamp || now < ds_q) begin
			elapsed = '0;
		end else begin
			elapsed = now - ds_q;
		end
		start = (elapsed >= TIME_WIDTH'(debounce));
		if (mode_d != srf_pkg::MODE_DIRTY) begin
			left = '1;
		end else if (start) begin
			left = '0;
		end else begin
			left = {1'b0, debounce - elapsed[srf_pkg::DEB_W-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= srf_pkg::MODE_NONE;
			reason_q <= srf_pkg::RSN_NONE;
			study_q  <= '0;
			world_q  <= '0;
			run_q    <= '0;
			wk_q     <= 1'b0;
			rk_q     <= 1'b0;
			gen_q    <= '0;
			ds_q     <= '0;
			rr_q     <= '0;
			disc_q   <= '0;
		end else if (advance) begin
			mode_q   <= mode_d;
			reason_q <= reason_d;
			study_q  <= study_d;
			world_q  <= world_d;
			run_q    <= run_d;
			wk_q     <= wk_d;
			rk_q     <= rk_d;
			gen_q    <= gen_d;
			ds_q     <= ds_d;
			rr_q     <= rr_d;
			disc_q   <= disc_d;
		end
	end

	always_comb begin
		res.changed         = changed;
		res.should_start    = (mode_d == srf_pkg::MODE_DIRTY) && start;
		res.ms_until_start  = signed'(left);
		res.generation      = gen_d;
		res.follow_state    = srf_pkg::mode_code(mode_d);
		res.dirty_reason    = reason_d;
		res.discarded_count = disc_d;
		res.rerun_count     = rr_d;
	end

	`SRF_ASSERT(a_gen_hold, clk, arst_n, !advance |=> $stable(gen_q))
	`SRF_ASSERT(a_rerun_step, clk, arst_n, (advance && op == srf_pkg::OP_RUN_STARTED) |=> rr_q == $past(rr_q) + GW'(1))
	`SRF_ASSERT(a_clear, clk, arst_n, (advance && op == srf_pkg::OP_CLEAR) |=> (mode_q == srf_pkg::MODE_NONE && !wk_q && !rk_q))

endmodule

// ===== sv/stale_result_follower_top.sv =====
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: operation; tdata: signatures, now_ms, run_generation
// m_*       out  m_tvalid/m_tready  tdata: status result
// APB       in   psel/penable       debounce_ms at address 0
//
// One request per clock when the result side keeps up; each request passes
// through the input register, then the result register.
// Status is computed combinationally between the two registers.
// A result held by m_tready low keeps the input register full; the block then
// takes no new request until the result register drains.
// arst_n clears all follower state and loads debounce_ms with 300.
`include "stale_result_follower_top_macros.svh"

module stale_result_follower_top #(
	parameter int SIG_WIDTH  = 32,
	parameter int TIME_WIDTH = 48
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// geometry_sig, sun_sig, sampling_sig, now_ms, run_generation, zero fill
	input  logic [((3*SIG_WIDTH+TIME_WIDTH+32+7)/8)*8-1:0] s_tdata,
	// operation
	input  logic [srf_pkg::OP_W-1:0]                 s_tuser,
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	// changed, should_start, ms_until_start, generation, follow_state,
	// dirty_reason, discarded_count, rerun_count
	output logic [$bits(srf_pkg::result_t)-1:0]      m_tdata,
	input  logic                                     psel,
	input  logic                                     penable,
	input  logic                                     pwrite,
	input  logic [srf_pkg::ADDR_W-1:0]               paddr,
	input  logic [srf_pkg::APB_W-1:0]                pwdata,
	output logic [srf_pkg::APB_W-1:0]                prdata,
	output logic                                     pready
);

	localparam int NOW_LO = 3*SIG_WIDTH;
	localparam int TAG_LO = NOW_LO + TIME_WIDTH;

	logic                            valid_s1;
	srf_pkg::op_t                    op_s1;
	logic [2:0][SIG_WIDTH-1:0]       sig_s1;
	logic [TIME_WIDTH-1:0]           now_s1;
	logic [srf_pkg::GEN_W-1:0]       tag_s1;
	logic                            valid_s2;
	srf_pkg::result_t                res_s2;
	srf_pkg::result_t                res;
	logic [srf_pkg::DEB_W-1:0]       debounce;
	logic                            advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1     <= srf_pkg::op_t'(s_tuser);
			sig_s1[0] <= s_tdata[SIG_WIDTH-1:0];
			sig_s1[1] <= s_tdata[2*SIG_WIDTH-1:SIG_WIDTH];
			sig_s1[2] <= s_tdata[3*SIG_WIDTH-1:2*SIG_WIDTH];
			now_s1    <= s_tdata[TAG_LO-1:NOW_LO];
			tag_s1    <= s_tdata[TAG_LO+srf_pkg::GEN_W-1:TAG_LO];
		end
	end

	srf_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.debounce (debounce)
	);

	srf_core #(
		.SIG_WIDTH  (SIG_WIDTH),
		.TIME_WIDTH (TIME_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.op       (op_s1),
		.sig      (sig_s1),
		.now      (now_s1),
		.tag      (tag_s1),
		.debounce (debounce),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2;

	`SRF_ASSERT(a_adv_out, clk, arst_n, advance |=> m_tvalid)
	`SRF_ASSERT(a_stall_in, clk, arst_n, (valid_s1 && m_tvalid && !m_tready) |-> !s_tready)
	`SRF_ASSERT(a_acc_fill, clk, arst_n, (s_tvalid && s_tready) |=> valid_s1)

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import srf_pkg::*;

	typedef logic [2:0][31:0] sig_t;	// [0] geometry, [1] sun, [2] sampling

	localparam logic [OP_W-1:0] OP_RESERVED_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RESERVED_7 = 3'd7;
	localparam logic [ADDR_W-1:0] DEBOUNCE_ADDR = {REG_DEBOUNCE, 2'b00};

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	// geometry_sig, sun_sig, sampling_sig, now_ms, run_generation
	logic [175:0] s_tdata;
	// operation
	logic [OP_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	// changed, should_start, ms_until_start, generation, follow_state,
	// dirty_reason, discarded_count, rerun_count
	logic [$bits(result_t)-1:0] m_tdata;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [APB_W-1:0] pwdata;
	logic [APB_W-1:0] prdata;
	logic pready;

	stale_result_follower_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #1 clk = ~clk;

	// follower state as predicted
	state_code_t flw_mode = ST_NONE;
	reason_t flw_reason = RSN_NONE;
	sig_t study_sig = '0;
	sig_t seen_sig = '0;
	sig_t run_sig = '0;
	logic seen_valid = 1'b0;
	logic run_valid = 1'b0;
	logic [31:0] gen_count = '0;
	logic [47:0] dirty_start = '0;
	logic [31:0] rerun_total = '0;
	logic [31:0] discard_total = '0;
	logic [15:0] quiet_ms = DEBOUNCE_RST;

	result_t expected_status_q[$];
	logic [47:0] now_cursor = '0;
	int error_count = 0;
	int checked_count = 0;
	int sent_count = 0;
	int quiet_settings = 0;
	int op_seen [8];
	logic idle_on = 1'b0;
	int idle_pct = 0;
	int stall_left = 0;

	function automatic sig_t mk_sig(logic [31:0] geo, logic [31:0] sun, logic [31:0] smp);
		return {smp, sun, geo};
	endfunction

	function automatic reason_t first_moved(sig_t a, sig_t b);
		if (a[0] != b[0]) return RSN_GEOMETRY;
		if (a[1] != b[1]) return RSN_SUN;
		if (a[2] != b[2]) return RSN_SAMPLING;
		return RSN_NONE;
	endfunction

	function automatic void mark_dirty(reason_t why, logic [47:0] now);
		gen_count = gen_count + 1;
		flw_mode = ST_DIRTY;
		run_valid = 1'b0;
		flw_reason = why;
		dirty_start = now;
	endfunction

	function automatic void adopt_study(sig_t sig, logic [47:0] now);
		study_sig = sig;
		seen_sig = sig;
		seen_valid = 1'b1;
		flw_mode = ST_CURRENT;
		flw_reason = RSN_NONE;
		dirty_start = now;
		run_valid = 1'b0;
	endfunction

	function automatic logic observe_world(sig_t sig, logic [47:0] now);
		sig_t prev;
		sig_t base;
		reason_t why;
		prev = seen_sig;
		seen_sig = sig;
		seen_valid = 1'b1;
		if (flw_mode == ST_NONE)
			return 1'b0;
		// compare against the run target while a run is in flight
		if ((flw_mode == ST_STARTING || flw_mode == ST_UPDATING) && run_valid)
			base = run_sig;
		else
			base = study_sig;
		why = first_moved(base, sig);
		if (why == RSN_NONE) begin
			if (flw_mode == ST_DIRTY) begin
				flw_mode = ST_CURRENT;
				flw_reason = RSN_NONE;
				return 1'b1;
			end
			return 1'b0;
		end
		if (flw_mode == ST_DIRTY && flw_reason == why) begin
			if (prev != sig)
				dirty_start = now;
			return 1'b0;
		end
		mark_dirty(why, now);
		return 1'b1;
	endfunction

	function automatic result_t predict_status(logic [2:0] op, sig_t sig, logic [47:0] now,
			logic [31:0] tag);
		result_t r;
		logic [47:0] waited;
		logic hit;
		hit = 1'b0;
		case (op)
			OP_OBSERVE: hit = observe_world(sig, now);
			OP_RUN_STARTED: begin
				flw_mode = ST_UPDATING;
				seen_sig = sig;
				run_sig = sig;
				seen_valid = 1'b1;
				run_valid = 1'b1;
				rerun_total = rerun_total + 1;
			end
			OP_RUN_DONE: begin
				if (tag != gen_count) begin
					discard_total = discard_total + 1;
				end else if (seen_valid && sig != seen_sig) begin
					discard_total = discard_total + 1;
					mark_dirty(first_moved(sig, seen_sig), now);
				end else begin
					adopt_study(sig, now);
					hit = 1'b1;
				end
			end
			OP_RUN_FAILED: begin
				if (tag != gen_count)
					discard_total = discard_total + 1;
				else
					flw_mode = ST_FAILED;
			end
			OP_ADOPT: adopt_study(sig, now);
			OP_CLEAR: begin
				flw_mode = ST_NONE;
				flw_reason = RSN_NONE;
				study_sig = '0;
				seen_sig = '0;
				run_sig = '0;
				seen_valid = 1'b0;
				run_valid = 1'b0;
				gen_count = gen_count + 1;
				dirty_start = '0;
			end
			default: ;
		endcase
		r = '0;
		r.changed = hit;
		r.should_start = 1'b0;
		r.ms_until_start = '1;
		if (flw_mode == ST_DIRTY) begin
			// time going backwards counts as no time elapsed
			waited = (now >= dirty_start) ? now - dirty_start : '0;
			if (waited >= quiet_ms) begin
				r.should_start = 1'b1;
				r.ms_until_start = '0;
			end else begin
				r.ms_until_start = {1'b0, quiet_ms - waited[15:0]};
			end
		end
		r.generation = gen_count;
		r.follow_state = flw_mode;
		r.dirty_reason = flw_reason;
		r.discarded_count = discard_total;
		r.rerun_count = rerun_total;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (error_count < 40)
			$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
				checked_count, name, got, want));
	endtask

	always @(posedge clk) begin : status_monitor
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata);
			if (expected_status_q.size() == 0) begin
				report_mismatch("status result with no request pending");
			end else begin
				want = expected_status_q.pop_front();
				check_field("changed", 32'(got.changed), 32'(want.changed));
				check_field("should_start", 32'(got.should_start), 32'(want.should_start));
				check_field("ms_until_start", 32'(got.ms_until_start),
					32'(want.ms_until_start));
				check_field("generation", got.generation, want.generation);
				check_field("follow_state", 32'(got.follow_state), 32'(want.follow_state));
				check_field("dirty_reason", 32'(got.dirty_reason), 32'(want.dirty_reason));
				check_field("discarded_count", got.discarded_count, want.discarded_count);
				check_field("rerun_count", got.rerun_count, want.rerun_count);
				checked_count++;
			end
		end
	end

	// result side back-pressure in bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 99) < idle_pct) begin
			stall_left <= $urandom_range(0, 5);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_request(input logic [2:0] op, input sig_t sig, input logic [47:0] now,
			input logic [31:0] tag);
		result_t want;
		if (idle_on && $urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {tag, now, sig};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		want = predict_status(op, sig, now, tag);
		expected_status_q.push_back(want);
		op_seen[op]++;
		sent_count++;
	endtask

	task automatic write_quiet_period(input logic [15:0] value);
		s_tvalid <= 1'b0;
		while (expected_status_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= DEBOUNCE_ADDR;
		pwdata <= {16'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		quiet_ms = value;
		quiet_settings++;
	endtask

	function automatic sig_t shaped_signature();
		sig_t s;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			s = study_sig;
		end else if (pick < 65) begin
			s = seen_sig;
		end else if (pick < 90) begin
			s = study_sig;
			s[$urandom_range(0, 2)] = $urandom;
		end else begin
			s = {$urandom, $urandom, $urandom};
		end
		return s;
	endfunction

	function automatic void advance_now();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 85)
			now_cursor = now_cursor + $urandom_range(0, 2 * quiet_ms + 2);
		else if (pick < 93)
			now_cursor = 48'({$urandom, $urandom});
		else if (now_cursor > 48'd500)
			now_cursor = now_cursor - $urandom_range(1, 500);
		else
			now_cursor = '0;
	endfunction

	task automatic send_random_request();
		int pick;
		logic [2:0] op;
		logic [31:0] tag;
		pick = $urandom_range(0, 99);
		if (pick < 45) op = OP_OBSERVE;
		else if (pick < 57) op = OP_RUN_STARTED;
		else if (pick < 72) op = OP_RUN_DONE;
		else if (pick < 79) op = OP_RUN_FAILED;
		else if (pick < 90) op = OP_ADOPT;
		else if (pick < 93) op = OP_CLEAR;
		else if (pick < 95) op = OP_RESERVED_6;
		else if (pick < 97) op = OP_RESERVED_7;
		else op = OP_OBSERVE;
		pick = $urandom_range(0, 9);
		if (pick < 7) tag = gen_count;
		else if (pick < 8) tag = gen_count - 1;
		else tag = $urandom;
		advance_now();
		send_request(op, shaped_signature(), now_cursor, tag);
	endtask

	task automatic test_observe_rules();
		sig_t a;
		sig_t b;
		a = mk_sig(32'h1111_0001, 32'h2222_0002, 32'h3333_0003);
		send_request(OP_OBSERVE, mk_sig(32'd1, 32'd2, 32'd3), 48'd0, '0);	// no study yet
		send_request(OP_RESERVED_6, '1, '1, '1);
		send_request(OP_RESERVED_7, '0, '0, '0);
		send_request(OP_ADOPT, a, 48'd100, '0);
		send_request(OP_OBSERVE, a, 48'd110, '0);
		b = a;
		b[0] = 32'hDEAD_BEEF;
		send_request(OP_OBSERVE, b, 48'd120, '0);
		send_request(OP_OBSERVE, b, 48'd200, '0);	// same reason, same world
		b[0] = 32'h0BAD_F00D;
		send_request(OP_OBSERVE, b, 48'd250, '0);	// same reason, quiet period restarts
		send_request(OP_OBSERVE, b, 48'd100, '0);	// clock went backwards
		send_request(OP_OBSERVE, b, 48'd550, '0);	// exactly elapsed
		send_request(OP_OBSERVE, a, 48'd560, '0);	// matches again while dirty
		b = a;
		b[1] = ~a[1];
		send_request(OP_OBSERVE, b, 48'd600, '0);
		b = a;
		b[2] = ~a[2];
		send_request(OP_OBSERVE, b, 48'd610, '0);
	endtask

	task automatic test_run_lifecycle();
		sig_t c;
		sig_t d;
		sig_t e;
		c = mk_sig(32'hC0C0_0000, 32'h0000_C1C1, 32'hC2C2_C2C2);
		send_request(OP_RUN_STARTED, c, 48'd1000, '0);
		send_request(OP_OBSERVE, c, 48'd1010, '0);	// matches run target
		d = c;
		d[0] = c[0] ^ 32'h1;
		send_request(OP_OBSERVE, d, 48'd1020, '0);
		send_request(OP_RUN_STARTED, d, 48'd1030, '0);
		send_request(OP_RUN_DONE, d, 48'd1040, gen_count + 5);	// stale tag
		e = d;
		e[1] = d[1] ^ 32'hFFFF_0000;
		send_request(OP_RUN_DONE, e, 48'd1050, gen_count);	// world moved on
		send_request(OP_RUN_STARTED, d, 48'd1060, '0);
		send_request(OP_RUN_DONE, d, 48'd1070, gen_count);
		send_request(OP_RUN_FAILED, d, 48'd1080, gen_count ^ 32'h1);
		send_request(OP_RUN_STARTED, d, 48'd1085, '0);
		send_request(OP_RUN_FAILED, d, 48'd1090, gen_count);
		send_request(OP_CLEAR, '0, 48'd1100, '0);
		send_request(OP_ADOPT, '1, 48'hFFFF_FFFF_FFFF, '0);
		send_request(OP_OBSERVE, '0, 48'hFFFF_FFFF_FFFF, '1);
	endtask

	task automatic test_quiet_period_limits();
		sig_t x;
		sig_t y;
		x = mk_sig(32'hA5A5_0000, 32'h5A5A_FFFF, 32'hFFFF_0000);
		write_quiet_period(16'd0);
		send_request(OP_ADOPT, x, 48'd5000, '0);
		y = x;
		y[2] = 32'h0000_FFFF;
		send_request(OP_OBSERVE, y, 48'd5000, '0);
		write_quiet_period(16'hFFFF);
		y = x;
		y[1] = '0;
		send_request(OP_OBSERVE, y, 48'd5001, '0);
		send_request(OP_OBSERVE, y, 48'd5001 + 48'd65534, '0);
		send_request(OP_OBSERVE, y, 48'd5001 + 48'd65535, '0);
		write_quiet_period(16'd1);
		send_request(OP_OBSERVE, x, 48'd80000, '0);
		now_cursor = 48'd80000;
	endtask

	task automatic test_random_traffic(input int count, input logic [15:0] quiet);
		write_quiet_period(quiet);
		idle_on = 1'b1;
		idle_pct = $urandom_range(10, 50);
		repeat (count) send_random_request();
	endtask

	task automatic test_full_rate_stream(input int count);
		write_quiet_period(16'($urandom_range(2, 400)));
		idle_on = 1'b0;
		repeat (count) send_random_request();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		foreach (op_seen[k]) op_seen[k] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_observe_rules();
		test_run_lifecycle();
		test_quiet_period_limits();
		test_random_traffic(250, DEBOUNCE_RST);
		test_random_traffic(180, 16'd0);
		test_random_traffic(180, 16'hFFFF);
		test_random_traffic(150, 16'd1);
		test_random_traffic(150, 16'($urandom_range(2, 65534)));
		test_full_rate_stream(200);

		s_tvalid <= 1'b0;
		while (expected_status_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);

		$display("covered %0d requests under %0d quiet period settings, %0d results compared",
			sent_count, quiet_settings, checked_count);
		$display("mix observe/start/done/fail/adopt/clear/reserved: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
			op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5],
			op_seen[6] + op_seen[7]);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/srf_pkg.sv
sv/srf_cfg.sv
sv/srf_core.sv
sv/stale_result_follower_top.sv
dv/tb_top.sv
